// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SDQ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdq assertion failed");

// Next-cycle implication, off during reset.
`define SDQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdq assertion failed");

`endif

// ----- rtl/sdq_pkg.sv -----
// Package for the sorted delay queue: sizes, codes, entry types, pointer helpers.
// No dependencies.
package sdq_pkg;

   localparam int DEPTH             = 16;
   localparam int ADDR_WIDTH        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH       = $clog2(DEPTH + 1);
   localparam int VALUE_WIDTH       = 16;
   localparam int ENTRY_COUNT_WIDTH = 5;

   typedef logic [ADDR_WIDTH-1:0]        addr_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;
   typedef logic [VALUE_WIDTH-1:0]       value_type;
   typedef logic [ENTRY_COUNT_WIDTH-1:0] entry_count_type;

   localparam count_type COUNT_FULL = COUNT_WIDTH'(DEPTH);
   localparam addr_type  ADDR_LAST  = ADDR_WIDTH'(DEPTH - 1);

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_POP      = 2'd1,
      CMD_DECREASE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      value_type tag;
      value_type remaining;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef struct packed {
      logic      greater;
      value_type sat_diff;
   } alu_result_type;

   function automatic addr_type ptr_next(input addr_type ptr);
      return (ptr == ADDR_LAST) ? '0 : ptr + 1'b1;
   endfunction

   function automatic addr_type ptr_prev(input addr_type ptr);
      return (ptr == '0) ? ADDR_LAST : ptr - 1'b1;
   endfunction

   function automatic entry_count_type count_low(input count_type count);
      logic [COUNT_WIDTH+ENTRY_COUNT_WIDTH-1:0] wide;
      wide = {{ENTRY_COUNT_WIDTH{1'b0}}, count};
      return wide[ENTRY_COUNT_WIDTH-1:0];
   endfunction

endpackage

// ----- rtl/sdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sdq_alu.sv -----
// Shared compare / saturating subtract unit for the delay queue sequencer.
// Depends on sdq_pkg.
module sdq_alu (
   input  sdq_pkg::value_type      entry_value,
   input  sdq_pkg::value_type      operand,
   output sdq_pkg::alu_result_type result
);
   import sdq_pkg::*;

   value_type diff;

   assign diff           = entry_value - operand;
   assign result.greater = entry_value > operand;
   assign result.sat_diff = result.greater ? diff : '0;

endmodule

// ----- rtl/sorted_delay_queue_top.sv -----
// Top level of the sorted delay queue: sequencer, entry RAM and shared ALU.
// Depends on sdq_pkg, sdq_ram and sdq_alu.
//
// Usage:
//   Input channel: drive req_* and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high until the result
//   is issued.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_* valid;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Entries sit in a circular buffer in one RAM; each entry visited takes a
//   RAM read, then a compare/write through the shared unit.
//   Steps from accept to rsp_valid, ending with a read of the head, if any:
//     insert: walk back from the tail until the slot fits, then write; none if full
//     pop: read and remove the head entry; none if empty
//     decrease: read and update every held entry; none if empty
//     unused code: none
//   A new item may be started in the cycle rsp_valid is high.
//   Reset empties the queue at once; no clearing pass is needed.
module sorted_delay_queue_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  sdq_pkg::value_type           req_job_tag,
   input  sdq_pkg::value_type           req_delay_seconds,
   input  sdq_pkg::value_type           req_decrease_amount,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output sdq_pkg::value_type           rsp_popped_tag,
   output sdq_pkg::value_type           rsp_popped_remaining,
   output logic                         rsp_head_valid,
   output sdq_pkg::value_type           rsp_head_remaining,
   output sdq_pkg::entry_count_type     rsp_entry_count
);
   import sdq_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      INS_READ,
      INS_WAIT,
      INS_WRITE,
      POP_READ,
      POP_WAIT,
      DEC_READ,
      DEC_WAIT,
      HEAD_READ,
      HEAD_WAIT
   } state_type;

   state_type       state_ff, state_in;
   addr_type        head_ff, head_in;
   addr_type        tail_ff, tail_in;
   addr_type        cur_ff, cur_in;
   count_type       count_ff, count_in;
   count_type       left_ff, left_in;
   value_type       tag_ff, tag_in;
   value_type       delay_ff, delay_in;
   value_type       amount_ff, amount_in;
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   value_type       rsp_popped_tag_ff, rsp_popped_tag_in;
   value_type       rsp_popped_remaining_ff, rsp_popped_remaining_in;
   logic            rsp_head_valid_ff, rsp_head_valid_in;
   value_type       rsp_head_remaining_ff, rsp_head_remaining_in;
   entry_count_type rsp_entry_count_ff, rsp_entry_count_in;

   logic           ram_wr_en;
   addr_type       ram_wr_addr;
   entry_type      ram_wr_data;
   logic           ram_rd_en;
   addr_type       ram_rd_addr;
   entry_type      ram_rd_data;
   value_type      alu_operand;
   alu_result_type alu_result;

   sdq_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(DEPTH)
   ) u_sdq_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign alu_operand = (state_ff == INS_WAIT) ? delay_ff : amount_ff;

   sdq_alu u_sdq_alu (
      .entry_value(ram_rd_data.remaining),
      .operand    (alu_operand),
      .result     (alu_result)
   );

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         INS_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_prev(cur_ff);
         end
         INS_WAIT: begin
            ram_wr_en = alu_result.greater;
         end
         INS_WRITE: begin
            ram_wr_en             = 1'b1;
            ram_wr_data.tag       = tag_ff;
            ram_wr_data.remaining = delay_ff;
         end
         DEC_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_ff;
         end
         DEC_WAIT: begin
            ram_wr_en             = 1'b1;
            ram_wr_data.remaining = alu_result.sat_diff;
         end
         POP_READ, HEAD_READ: begin
            ram_rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in                = state_ff;
      head_in                 = head_ff;
      tail_in                 = tail_ff;
      cur_in                  = cur_ff;
      count_in                = count_ff;
      left_in                 = left_ff;
      tag_in                  = tag_ff;
      delay_in                = delay_ff;
      amount_in               = amount_ff;
      rsp_valid_in            = 1'b0;
      rsp_status_in           = rsp_status_ff;
      rsp_popped_tag_in       = rsp_popped_tag_ff;
      rsp_popped_remaining_in = rsp_popped_remaining_ff;
      rsp_head_valid_in       = rsp_head_valid_ff;
      rsp_head_remaining_in   = rsp_head_remaining_ff;
      rsp_entry_count_in      = rsp_entry_count_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               tag_in                  = req_job_tag;
               delay_in                = req_delay_seconds;
               amount_in               = req_decrease_amount;
               rsp_status_in           = STATUS_DONE;
               rsp_popped_tag_in       = '0;
               rsp_popped_remaining_in = '0;
               cur_in                  = tail_ff;
               left_in                 = count_ff;
               state_in                = HEAD_READ;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff == COUNT_FULL) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = INS_WRITE;
                     end else begin
                        state_in = INS_READ;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = POP_READ;
                     end
                  end
                  CMD_DECREASE: begin
                     cur_in = head_ff;
                     if (count_ff != '0) begin
                        state_in = DEC_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         INS_READ: begin
            state_in = INS_WAIT;
         end
         INS_WAIT: begin
            if (alu_result.greater) begin
               cur_in   = ptr_prev(cur_ff);
               left_in  = left_ff - 1'b1;
               state_in = (left_ff == count_type'(1)) ? INS_WRITE : INS_READ;
            end else begin
               state_in = INS_WRITE;
            end
         end
         INS_WRITE: begin
            tail_in  = ptr_next(tail_ff);
            count_in = count_ff + 1'b1;
            state_in = HEAD_READ;
         end
         POP_READ: begin
            state_in = POP_WAIT;
         end
         POP_WAIT: begin
            rsp_popped_tag_in       = ram_rd_data.tag;
            rsp_popped_remaining_in = ram_rd_data.remaining;
            head_in                 = ptr_next(head_ff);
            count_in                = count_ff - 1'b1;
            state_in                = HEAD_READ;
         end
         DEC_READ: begin
            state_in = DEC_WAIT;
         end
         DEC_WAIT: begin
            cur_in   = ptr_next(cur_ff);
            left_in  = left_ff - 1'b1;
            state_in = (left_ff == count_type'(1)) ? HEAD_READ : DEC_READ;
         end
         HEAD_READ: begin
            rsp_entry_count_in = count_low(count_ff);
            if (count_ff == '0) begin
               rsp_head_valid_in     = 1'b0;
               rsp_head_remaining_in = '0;
               rsp_valid_in          = 1'b1;
               state_in              = IDLE;
            end else begin
               state_in = HEAD_WAIT;
            end
         end
         HEAD_WAIT: begin
            rsp_head_valid_in     = 1'b1;
            rsp_head_remaining_in = ram_rd_data.remaining;
            rsp_valid_in          = 1'b1;
            state_in              = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff                  <= cur_in;
      left_ff                 <= left_in;
      tag_ff                  <= tag_in;
      delay_ff                <= delay_in;
      amount_ff               <= amount_in;
      rsp_status_ff           <= rsp_status_in;
      rsp_popped_tag_ff       <= rsp_popped_tag_in;
      rsp_popped_remaining_ff <= rsp_popped_remaining_in;
      rsp_head_valid_ff       <= rsp_head_valid_in;
      rsp_head_remaining_ff   <= rsp_head_remaining_in;
      rsp_entry_count_ff      <= rsp_entry_count_in;
   end

   assign busy                 = (state_ff != IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_popped_tag       = rsp_popped_tag_ff;
   assign rsp_popped_remaining = rsp_popped_remaining_ff;
   assign rsp_head_valid       = rsp_head_valid_ff;
   assign rsp_head_remaining   = rsp_head_remaining_ff;
   assign rsp_entry_count      = rsp_entry_count_ff;

endmodule

// ----- rtl/sdq_checker.sv -----
// Port-level checker for the sorted delay queue, bound to the top level.
// Depends on sdq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdq_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [1:0]               rsp_status,
   input sdq_pkg::value_type       rsp_popped_tag,
   input logic                     rsp_head_valid,
   input sdq_pkg::value_type       rsp_head_remaining,
   input sdq_pkg::entry_count_type rsp_entry_count
);
   import sdq_pkg::*;

   logic empty_rsp;
   logic head_cleared;
   logic empty_pop_rsp;
   logic pop_cleared;

   assign empty_rsp     = rsp_valid && !rsp_head_valid;
   assign head_cleared  = (rsp_head_remaining == '0) && (rsp_entry_count == '0);
   assign empty_pop_rsp = rsp_valid && (rsp_status == STATUS_EMPTY);
   assign pop_cleared   = (rsp_popped_tag == '0) && !rsp_head_valid;

   // an accepted item holds off the next one
   `SDQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // result frees the block
   `SDQ_ASSERT_IMPLY(a_rsp_not_busy, clock, reset, rsp_valid, !busy)
   // no two results back to back
   `SDQ_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // empty queue reports nothing at the head
   `SDQ_ASSERT_IMPLY(a_empty_head, clock, reset, empty_rsp, head_cleared)
   // failed pop returns no entry and no head
   `SDQ_ASSERT_IMPLY(a_empty_pop, clock, reset, empty_pop_rsp, pop_cleared)

endmodule

bind sorted_delay_queue_top sdq_checker u_sdq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_popped_tag    (rsp_popped_tag),
   .rsp_head_valid    (rsp_head_valid),
   .rsp_head_remaining(rsp_head_remaining),
   .rsp_entry_count   (rsp_entry_count)
);
